[rtl/assert_macros.svh]
// Assertion macros for the top RTL module of the ring assignment block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk, disabled while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication on clk, disabled while rst_n is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/lpra_pkg.sv]
// Shared types, constants and tables for the lidar ring assignment pipeline.
package lpra_pkg;

  // Defaults for the top-level parameters.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_RINGS_DEF    = 128;

  // Field and datapath widths.
  localparam int COORD_W  = 24;
  localparam int SQ_W     = 48;
  localparam int RAD_W    = 64;
  localparam int SQ_STEPS = 32;
  localparam int CW       = 36;
  localparam int ANG_W    = 32;
  localparam int ATAN_LEN = 24;
  localparam int INT_W    = 16;
  localparam int RING_W   = 7;
  localparam int N2_W     = 24;
  localparam int DSPAN_W  = 15;
  localparam int FOV_W    = 15;
  localparam int RC_W     = 8;
  localparam int CFG_W    = 15;

  // Intensity: floor(range / 100) by reciprocal multiply, capped at 255.0 in Q8.8.
  localparam logic [25:0] RECIP_100  = 26'd42949673;
  localparam logic [31:0] INT_CAP_IN = 32'd6528000;
  localparam logic [15:0] INT_CAP    = 16'd65280;

  // Register reset values.
  localparam logic [RC_W-1:0]         RING_COUNT_RST = 8'd16;
  localparam logic signed [FOV_W-1:0] FOV_BOTTOM_RST = -15'sd1687;
  localparam logic signed [FOV_W-1:0] FOV_TOP_RST    = 15'sd1687;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RING_COUNT = 2'd0,
    CFG_FOV_BOTTOM = 2'd1,
    CFG_FOV_TOP    = 2'd2
  } cfg_idx_t;

  // Input and result payloads.
  typedef struct packed {
    logic signed [COORD_W-1:0] x_mm;
    logic signed [COORD_W-1:0] y_mm;
    logic signed [COORD_W-1:0] z_mm;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x_mm;
    logic signed [COORD_W-1:0] out_y_mm;
    logic signed [COORD_W-1:0] out_z_mm;
    logic [INT_W-1:0]          intensity_q8;
    logic [RING_W-1:0]         ring_index;
  } out_t;

  // Point plus its finished intensity, carried along the later stages.
  typedef struct packed {
    in_t              pt;
    logic [INT_W-1:0] inten;
  } pay_t;

  // One lane of the digit-by-digit square root.
  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] res;
  } sq_lane_t;

  // Horizontal range lane and full range lane.
  typedef struct packed {
    sq_lane_t xy;
    sq_lane_t all;
  } sq_t;

  // Vectoring CORDIC state.
  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ANG_W-1:0] ang;
    logic                    zero;
  } cord_t;

  // Restoring divider state for the ring quotient.
  typedef struct packed {
    logic [N2_W-1:0]   rem;
    logic [RING_W-1:0] q;
    logic              drop;
  } div_t;

  // atan(2^-i) in hundredths of a degree times 2^16, rounded to nearest.
  function automatic logic [29:0] atan_cdeg_q16(input int idx);
    case (idx)
      0:       return 30'd294912000;
      1:       return 30'd174096719;
      2:       return 30'd91987925;
      3:       return 30'd46694507;
      4:       return 30'd23437865;
      5:       return 30'd11730358;
      6:       return 30'd5866610;
      7:       return 30'd2933484;
      8:       return 30'd1466764;
      9:       return 30'd733385;
      10:      return 30'd366693;
      11:      return 30'd183346;
      12:      return 30'd91673;
      13:      return 30'd45837;
      14:      return 30'd22918;
      15:      return 30'd11459;
      16:      return 30'd5730;
      17:      return 30'd2865;
      18:      return 30'd1432;
      19:      return 30'd716;
      20:      return 30'd358;
      21:      return 30'd179;
      22:      return 30'd90;
      23:      return 30'd45;
      default: return 30'd0;
    endcase
  endfunction

endpackage

[rtl/lpra_sqrt_cell.sv]
// One stage of the pipelined integer square root, two lanes side by side.
module lpra_sqrt_cell #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_i,
  input  lpra_pkg::sq_t   s_i,
  input  lpra_pkg::in_t   p_i,
  output logic            v_o,
  output lpra_pkg::sq_t   s_o,
  output lpra_pkg::in_t   p_o
);
  import lpra_pkg::*;

  // Trial bit of this stage: 4^(31-K).
  localparam logic [RAD_W-1:0] BIT_C = RAD_W'(1) << (62 - 2 * K);

  logic  v_r;
  sq_t   s_r;
  sq_t   s_nxt;
  in_t   p_r;

  // One result bit: subtract the trial value when it fits.
  function automatic sq_lane_t sq_step(input sq_lane_t l);
    sq_lane_t         o;
    logic [RAD_W-1:0] t;
    t = l.res + BIT_C;
    if (l.rem >= t) begin
      o.rem = l.rem - t;
      o.res = (l.res >> 1) + BIT_C;
    end else begin
      o.rem = l.rem;
      o.res = l.res >> 1;
    end
    return o;
  endfunction

  always_comb begin
    s_nxt.xy  = sq_step(s_i.xy);
    s_nxt.all = sq_step(s_i.all);
  end

  // Valid bit follows the pipeline enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  // Data moves to the next stage with the enable.
  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
      p_r <= p_i;
    end
  end

  assign v_o = v_r;
  assign s_o = s_r;
  assign p_o = p_r;

endmodule

[rtl/lpra_cordic_cell.sv]
// One vectoring CORDIC rotation stage for the elevation angle.
module lpra_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_i,
  input  lpra_pkg::cord_t c_i,
  input  lpra_pkg::pay_t  p_i,
  output logic            v_o,
  output lpra_pkg::cord_t c_o,
  output lpra_pkg::pay_t  p_o
);
  import lpra_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN_C = ANG_W'(atan_cdeg_q16(STEP));

  logic                 v_r;
  cord_t                c_r;
  cord_t                c_nxt;
  pay_t                 p_r;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  // Rotate clockwise when y is zero or positive, otherwise counterclockwise.
  always_comb begin
    dx = c_i.y >>> STEP;
    dy = c_i.x >>> STEP;
    c_nxt.zero = c_i.zero;
    if (!c_i.y[CW-1]) begin
      c_nxt.x   = c_i.x + dx;
      c_nxt.y   = c_i.y - dy;
      c_nxt.ang = c_i.ang + ATAN_C;
    end else begin
      c_nxt.x   = c_i.x - dx;
      c_nxt.y   = c_i.y + dy;
      c_nxt.ang = c_i.ang - ATAN_C;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
      p_r <= p_i;
    end
  end

  assign v_o = v_r;
  assign c_o = c_r;
  assign p_o = p_r;

endmodule

[rtl/lpra_div_cell.sv]
// One restoring division stage of the ring quotient; the top stage detects overflow.
module lpra_div_cell #(
  parameter int K = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [lpra_pkg::DSPAN_W-1:0]  d,
  input  logic                          v_i,
  input  lpra_pkg::div_t                s_i,
  input  lpra_pkg::pay_t                p_i,
  output logic                          v_o,
  output lpra_pkg::div_t                s_o,
  output lpra_pkg::pay_t                p_o
);
  import lpra_pkg::*;

  logic            v_r;
  div_t            s_r;
  div_t            s_nxt;
  pay_t            p_r;
  logic [N2_W-1:0] dk;
  logic            ge;

  assign dk = N2_W'(d) << K;
  assign ge = (s_i.rem >= dk);

  generate
    if (K == RING_W) begin : g_ovf
      // A quotient of 2^RING_W or more cannot be carried, so the point is dropped.
      always_comb begin
        s_nxt      = s_i;
        s_nxt.drop = s_i.drop | ge;
      end
    end else begin : g_bit
      // Subtract the shifted divisor when it fits and set this quotient bit.
      always_comb begin
        s_nxt = s_i;
        if (ge) begin
          s_nxt.rem  = s_i.rem - dk;
          s_nxt.q[K] = 1'b1;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
      p_r <= p_i;
    end
  end

  assign v_o = v_r;
  assign s_o = s_r;
  assign p_o = p_r;

endmodule

[rtl/lidar_point_ring_assign.sv]
// Lidar point ring assignment: range, intensity and vertical ring per point.
// From input to result: squares, square root, intensity, CORDIC, ring numerator,
// divider, output register; one point enters per cycle unless the pipeline holds.
// The whole pipeline advances together and holds while a result waits unaccepted.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
`include "assert_macros.svh"

module lidar_point_ring_assign #(
  parameter int CORDIC_STEPS = lpra_pkg::CORDIC_STEPS_DEF,
  parameter int MAX_RINGS    = lpra_pkg::MAX_RINGS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lpra_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lpra_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [lpra_pkg::CFG_W-1:0] cfg_wdata
);
  import lpra_pkg::*;

  localparam int DIV_CELLS = RING_W + 1;

  // Configuration registers.
  logic [RC_W-1:0]         ring_count_r;
  logic signed [FOV_W-1:0] fov_bottom_r;
  logic signed [FOV_W-1:0] fov_top_r;

  logic pipe_en;

  // Square stage.
  logic signed [2*COORD_W-1:0] xx;
  logic signed [2*COORD_W-1:0] yy;
  logic signed [2*COORD_W-1:0] zz;
  logic [SQ_W-1:0]             sxy_nxt;
  logic [SQ_W-1:0]             sall_nxt;
  logic                        sq_v_r;
  logic [SQ_W-1:0]             sxy_r;
  logic [SQ_W-1:0]             sall_r;
  in_t                         sq_p_r;

  // Square root chain.
  logic sq_v [0:SQ_STEPS];
  sq_t  sq_s [0:SQ_STEPS];
  in_t  sq_p [0:SQ_STEPS];

  // Intensity and CORDIC setup stage.
  logic [31:0]      res_xy;
  logic [31:0]      res_all;
  logic [48:0]      prod;
  cord_t            int_c_nxt;
  pay_t             int_p_nxt;
  logic             int_v_r;
  cord_t            int_c_r;
  pay_t             int_p_r;

  // CORDIC chain.
  logic  cd_v [0:CORDIC_STEPS];
  cord_t cd_c [0:CORDIC_STEPS];
  pay_t  cd_p [0:CORDIC_STEPS];

  // Ring numerator stage.
  logic [RC_W-1:0]         rings_eff;
  logic [RC_W-1:0]         rm1;
  logic signed [FOV_W:0]   dspan;
  logic [DSPAN_W-1:0]      dsp;
  logic                    fov_ok;
  logic signed [ANG_W-1:0] ang_f;
  logic signed [ANG_W:0]   a;
  logic [ANG_W-1:0]        a_pos;
  logic [39:0]             num;
  div_t                    rg_s_nxt;
  logic                    rg_v_r;
  div_t                    rg_s_r;
  pay_t                    rg_p_r;

  // Divider chain.
  logic dv_v [0:DIV_CELLS];
  div_t dv_s [0:DIV_CELLS];
  pay_t dv_p [0:DIV_CELLS];

  // Output register.
  logic keep;
  out_t out_data_nxt;
  logic out_valid_r;
  out_t out_data_r;
  logic ring_below;

  // Everything advances whenever the output register can take a result.
  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r <= RING_COUNT_RST;
      fov_bottom_r <= FOV_BOTTOM_RST;
      fov_top_r    <= FOV_TOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RING_COUNT: ring_count_r <= cfg_wdata[RC_W-1:0];
        CFG_FOV_BOTTOM: fov_bottom_r <= cfg_wdata;
        CFG_FOV_TOP:    fov_top_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Squares and the two sums of squares.
  assign xx       = in_data.x_mm * in_data.x_mm;
  assign yy       = in_data.y_mm * in_data.y_mm;
  assign zz       = in_data.z_mm * in_data.z_mm;
  assign sxy_nxt  = SQ_W'($unsigned(xx)) + SQ_W'($unsigned(yy));
  assign sall_nxt = sxy_nxt + SQ_W'($unsigned(zz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (pipe_en) begin
      sq_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sxy_r  <= sxy_nxt;
      sall_r <= sall_nxt;
      sq_p_r <= in_data;
    end
  end

  // Both radicands carry eight fractional bits in the root.
  assign sq_v[0] = sq_v_r;
  assign sq_s[0] = {{sxy_r, 16'h0000}, {RAD_W{1'b0}}, {sall_r, 16'h0000}, {RAD_W{1'b0}}};
  assign sq_p[0] = sq_p_r;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    lpra_sqrt_cell #(.K(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pipe_en),
      .v_i   (sq_v[i]),
      .s_i   (sq_s[i]),
      .p_i   (sq_p[i]),
      .v_o   (sq_v[i+1]),
      .s_o   (sq_s[i+1]),
      .p_o   (sq_p[i+1])
    );
  end

  // Intensity by reciprocal multiply with cap, and the CORDIC start vector.
  assign res_xy  = sq_s[SQ_STEPS].xy.res[31:0];
  assign res_all = sq_s[SQ_STEPS].all.res[31:0];
  assign prod    = 49'(res_all[22:0]) * 49'(RECIP_100);

  always_comb begin
    int_p_nxt.pt    = sq_p[SQ_STEPS];
    int_p_nxt.inten = (res_all >= INT_CAP_IN) ? INT_CAP : prod[47:32];
    int_c_nxt.x     = $signed({{(CW-32){1'b0}}, res_xy});
    int_c_nxt.y     = $signed({{(CW-32){sq_p[SQ_STEPS].z_mm[COORD_W-1]}},
                               sq_p[SQ_STEPS].z_mm, 8'h00});
    int_c_nxt.ang   = '0;
    int_c_nxt.zero  = (res_xy == 32'd0) && (sq_p[SQ_STEPS].z_mm == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_v_r <= 1'b0;
    end else if (pipe_en) begin
      int_v_r <= sq_v[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      int_c_r <= int_c_nxt;
      int_p_r <= int_p_nxt;
    end
  end

  assign cd_v[0] = int_v_r;
  assign cd_c[0] = int_c_r;
  assign cd_p[0] = int_p_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    lpra_cordic_cell #(.STEP(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pipe_en),
      .v_i   (cd_v[i]),
      .c_i   (cd_c[i]),
      .p_i   (cd_p[i]),
      .v_o   (cd_v[i+1]),
      .c_o   (cd_c[i+1]),
      .p_o   (cd_p[i+1])
    );
  end

  // Effective ring count and field of view span.
  assign rings_eff = (int'(ring_count_r) > MAX_RINGS) ? RC_W'(MAX_RINGS) : ring_count_r;
  assign rm1       = rings_eff - 8'd1;
  assign fov_ok    = (fov_top_r > fov_bottom_r);
  assign dspan     = 16'(fov_top_r) - 16'(fov_bottom_r);
  assign dsp       = dspan[DSPAN_W-1:0];

  // Numerator of the ring quotient; the Q16 scale cancels against the span.
  assign ang_f = cd_c[CORDIC_STEPS].zero ? '0 : cd_c[CORDIC_STEPS].ang;
  assign a     = 33'(ang_f) - 33'($signed({fov_bottom_r, 16'h0000}));
  assign a_pos = a[ANG_W] ? '0 : a[ANG_W-1:0];
  assign num   = 40'(a_pos) * 40'(rm1);

  always_comb begin
    rg_s_nxt.rem  = num[39:16];
    rg_s_nxt.q    = '0;
    rg_s_nxt.drop = (rings_eff == '0) || !fov_ok || (a[ANG_W] && (rm1 != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rg_v_r <= 1'b0;
    end else if (pipe_en) begin
      rg_v_r <= cd_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rg_s_r <= rg_s_nxt;
      rg_p_r <= cd_p[CORDIC_STEPS];
    end
  end

  assign dv_v[0] = rg_v_r;
  assign dv_s[0] = rg_s_r;
  assign dv_p[0] = rg_p_r;

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    lpra_div_cell #(.K(RING_W - j)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pipe_en),
      .d     (dsp),
      .v_i   (dv_v[j]),
      .s_i   (dv_s[j]),
      .p_i   (dv_p[j]),
      .v_o   (dv_v[j+1]),
      .s_o   (dv_s[j+1]),
      .p_o   (dv_p[j+1])
    );
  end

  // A result is kept only when its ring lies below the ring count.
  assign keep = dv_v[DIV_CELLS] && !dv_s[DIV_CELLS].drop &&
                ({1'b0, dv_s[DIV_CELLS].q} < rings_eff);

  always_comb begin
    out_data_nxt.out_x_mm     = dv_p[DIV_CELLS].pt.x_mm;
    out_data_nxt.out_y_mm     = dv_p[DIV_CELLS].pt.y_mm;
    out_data_nxt.out_z_mm     = dv_p[DIV_CELLS].pt.z_mm;
    out_data_nxt.intensity_q8 = dv_p[DIV_CELLS].inten;
    out_data_nxt.ring_index   = dv_s[DIV_CELLS].q;
  end

  // Output register holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ring_below = ({1'b0, out_data_r.ring_index} < rings_eff);

  // A delivered ring is always below the effective ring count.
  `ASSERT_IMPL(a_ring_in_range, out_valid_r, ring_below, "ring index not below ring count")
  // No result leaves while the field of view is empty or inverted.
  `ASSERT_IMPL(a_fov_order, out_valid_r, fov_ok, "result with inverted field of view")
  // A stalled pipeline keeps its last stage in place.
  `ASSERT_CLK(a_stall_hold, !pipe_en |=> $stable(dv_v[DIV_CELLS]), "last stage moved")

endmodule

[test/lidar_point_ring_assign_check.sv]
// Checker for the lidar ring assignment block: predicts each result and compares it.
`timescale 1ns / 100ps

module lidar_point_ring_assign_check (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  lpra_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  lpra_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [14:0]    cfg_wdata,
  output int             fail_count,
  output int             pending
);
  import lpra_pkg::*;

  localparam int STEPS = 16;
  localparam int RING_CAP = 128;

  // Arctangent table in hundredths of a degree times 2^16.
  localparam longint ATAN_Q16 [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  logic [7:0] rings_reg;
  longint     fov_lo;
  longint     fov_hi;
  out_t       ring_queue[$];

  // Integer square root, digit by digit.
  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned rem, res, b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC elevation; shifts of signed values round toward minus infinity.
  function automatic longint elev_q16(input longint xv, input longint yv);
    longint ang, dx, dy;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx;
        yv -= dy;
        ang += ATAN_Q16[i];
      end else begin
        xv -= dx;
        yv += dy;
        ang -= ATAN_Q16[i];
      end
    end
    return ang;
  endfunction

  // Works out the result for one point; returns 0 when the point is dropped.
  function automatic bit ring_predict(input in_t p, output out_t r);
    longint x, y, z, rxy, ang, num, den, ring, rings;
    longint unsigned sxy, sall, inten;
    x = p.x_mm;
    y = p.y_mm;
    z = p.z_mm;
    sxy = x * x + y * y;
    sall = sxy + z * z;
    inten = root64(sall << 16) / 100;
    if (inten > 65280) inten = 65280;
    rxy = root64(sxy << 16);
    ang = elev_q16(rxy, z * 256);
    rings = rings_reg;
    if (rings > RING_CAP) rings = RING_CAP;
    if (rings == 0 || fov_hi <= fov_lo) return 0;
    num = (ang - fov_lo * 65536) * (rings - 1);
    den = (fov_hi - fov_lo) * 65536;
    if (num < 0) return 0;
    ring = num / den;
    if (ring >= rings || ring >= 128) return 0;
    r.out_x_mm = p.x_mm;
    r.out_y_mm = p.y_mm;
    r.out_z_mm = p.z_mm;
    r.intensity_q8 = inten[15:0];
    r.ring_index = ring[6:0];
    return 1;
  endfunction

  // Track registers, predict on input transfers, compare on result transfers.
  always @(posedge clk) begin
    out_t want, r;
    if (!rst_n) begin
      rings_reg <= 8'd16;
      fov_lo <= -1687;
      fov_hi <= 1687;
      ring_queue.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RING_COUNT: rings_reg <= cfg_wdata[7:0];
          CFG_FOV_BOTTOM: fov_lo <= longint'($signed(cfg_wdata));
          CFG_FOV_TOP:    fov_hi <= longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (in_valid && in_ready && ring_predict(in_data, r)) ring_queue = {ring_queue, r};
      if (out_valid && out_ready) begin
        if (ring_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = ring_queue.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: expected x %0d y %0d z %0d int %0d ring %0d,",
                       want.out_x_mm, want.out_y_mm, want.out_z_mm, want.intensity_q8,
                       want.ring_index, " got x %0d y %0d z %0d int %0d ring %0d",
                       out_data.out_x_mm, out_data.out_y_mm, out_data.out_z_mm,
                       out_data.intensity_q8, out_data.ring_index);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= ring_queue.size();
    end
  end
endmodule

[test/lidar_point_ring_assign_test.sv]
// Top of the ring assignment testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module lidar_point_ring_assign_test;
  import lpra_pkg::*;

  localparam int LATENCY = 60;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [14:0] cfg_wdata = '0;
  int         fail_count;
  int         pending;
  int         cycles = 0;
  bit         hold_off = 0;

  always #1 clk = ~clk;

  lidar_point_ring_assign dut (.*);

  lidar_point_ring_assign_check checker_i (.*);

  // Gap length: mostly short, sometimes long.
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) < 70) || (cycles % 2000 < 300);
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until no result is expected for long enough that the pipeline is empty.
  task automatic drain();
    int quiet;
    quiet = 0;
    while (quiet < LATENCY + 10) begin
      @(posedge clk);
      if (pending == 0) quiet++;
      else quiet = 0;
    end
  endtask

  // Offers one point and waits for its transfer.
  task automatic send_point(input logic [23:0] x, input logic [23:0] y,
                            input logic [23:0] z);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{x_mm: x, y_mm: y, z_mm: z};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 400000)) - 200000);
      2: return 24'($signed($urandom_range(0, 4000)) - 2000);
      default: return 24'($signed($urandom_range(0, 60000)) - 30000);
    endcase
  endfunction

  // Random points in a cone around the field of view so most are kept.
  task automatic random_points(input int n);
    logic [23:0] x, y, z;
    longint h;
    for (int i = 0; i < n; i++) begin
      x = rand_coord();
      y = rand_coord();
      if ($urandom_range(0, 3) != 0) begin
        h = $signed(x);
        if (h < 0) h = -h;
        z = 24'(($signed($urandom_range(0, 2000)) - 1000) * (h + 1) / 1000);
      end else begin
        z = rand_coord();
      end
      send_point(x, y, z);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, origin, axes.
    send_point(24'h000000, 24'h000000, 24'h000000);
    send_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_point(24'h800000, 24'h000000, 24'h000000);
    send_point(24'h7fffff, 24'h000000, 24'h000000);
    send_point(24'h000000, 24'h000000, 24'h7fffff);
    send_point(24'h000000, 24'h000000, 24'h800000);
    send_point(24'd1000, 24'd0, 24'd100);
    send_point(24'd1000, 24'd0, -24'sd100);
    send_point(24'd25, 24'd0, 24'd0);
    send_point(24'h000001, 24'hffffff, 24'h000001);
    send_point(24'd10000, 24'd10000, 24'd0);
    in_valid <= 1'b0;
    drain();

    // Long receiver hold-off while the sender keeps offering points.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_points(150);
    join
    drain();

    // Field extremes and odd settings.
    write_reg(CFG_RING_COUNT, 15'd128);
    write_reg(CFG_FOV_BOTTOM, -15'sd9000);
    write_reg(CFG_FOV_TOP, 15'sd9000);
    send_point(24'd0, 24'd0, 24'h7fffff);
    send_point(24'd0, 24'd0, 24'h800000);
    send_point(24'd0, 24'd0, 24'd0);
    random_points(200);
    drain();

    write_reg(CFG_RING_COUNT, 15'd1);
    send_point(24'd500, 24'd0, 24'd300);
    send_point(24'd500, 24'd0, -24'sd300);
    in_valid <= 1'b0;
    drain();

    write_reg(CFG_RING_COUNT, 15'd0);
    random_points(20);
    drain();

    write_reg(CFG_RING_COUNT, 15'd255);
    random_points(100);
    drain();

    write_reg(CFG_RING_COUNT, 15'd2);
    write_reg(CFG_FOV_BOTTOM, 15'sd100);
    write_reg(CFG_FOV_TOP, 15'sd100);
    random_points(20);
    drain();

    write_reg(CFG_FOV_TOP, -15'sd100);
    random_points(20);
    drain();

    write_reg(CFG_FOV_BOTTOM, -15'sd3000);
    write_reg(CFG_FOV_TOP, 15'sd1000);
    write_reg(CFG_RING_COUNT, 15'd64);
    send_point(24'd0, 24'd0, 24'd0);
    random_points(250);
    drain();

    write_reg(CFG_RING_COUNT, 15'd127);
    write_reg(CFG_FOV_BOTTOM, -15'sd4500);
    write_reg(CFG_FOV_TOP, 15'sd4500);
    random_points(200);
    drain();

    write_reg(CFG_RING_COUNT, 15'd16);
    write_reg(CFG_FOV_BOTTOM, -15'sd1687);
    write_reg(CFG_FOV_TOP, 15'sd1687);
    random_points(200);
    drain();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
